FILE: rtl/core/greedy_job_server_assigner_top_macros.svh
// ============================================================================
// greedy_job_server_assigner_top_macros.svh
// Assertion macros shared by the job server assigner.
// ============================================================================
`ifndef GREEDY_JOB_SERVER_ASSIGNER_TOP_MACROS_SVH
`define GREEDY_JOB_SERVER_ASSIGNER_TOP_MACROS_SVH

// Checked on every clock edge outside of reset.
`define GJSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define GJSA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/core/gjsa_pkg.sv
// ============================================================================
// gjsa_pkg
// Beat types, server entry layout and constants of the job server assigner.
// ============================================================================
package gjsa_pkg;

    localparam int JOB_W  = 16;
    localparam int SRV_W  = 3;
    localparam int TIME_W = 16;
    localparam int COST_W = 16;
    localparam int CAP_W  = 24;
    localparam int SUM_W  = 32;
    localparam int CNT_W  = 16;
    localparam int BEST_W = 17;

    localparam logic       OP_LOAD  = 1'b0;
    localparam logic       OP_OFFER = 1'b1;

    localparam logic [BEST_W-1:0] NO_TIME = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX = '1;

    typedef struct packed {
        logic              opcode;
        logic [JOB_W-1:0]  job_index;
        logic [SRV_W-1:0]  server_index;
        logic [TIME_W-1:0] run_time;
        logic [COST_W-1:0] job_cost;
        logic [CAP_W-1:0]  capacity;
        logic              last_server;
    } t_in_beat;

    typedef struct packed {
        logic [JOB_W-1:0]  job_number;
        logic              assigned;
        logic [SRV_W-1:0]  chosen_server;
        logic [COST_W-1:0] charged_cost;
        logic [CNT_W-1:0]  server_job_count;
        logic [SUM_W-1:0]  total_cost;
    } t_out_beat;

    typedef struct packed {
        logic [CAP_W-1:0] remaining_capacity;
        logic [SUM_W-1:0] server_cost_sum;
        logic [CNT_W-1:0] jobs_on_server;
    } t_srv_entry;

endpackage

FILE: rtl/core/gjsa_entry_store.sv
// ============================================================================
// gjsa_entry_store
// Per-server state memory with registered read, valid bits that make unwritten
// entries read as zero, and forwarding of a write made at the read edge.
// ============================================================================
module gjsa_entry_store #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  gjsa_pkg::t_srv_entry  i_wr_data,
    output gjsa_pkg::t_srv_entry  o_rd_data
);
    import gjsa_pkg::*;

    t_srv_entry       mem [DEPTH];
    logic [DEPTH-1:0] r_ok;
    t_srv_entry       r_rd;
    logic             r_rd_ok;
    logic             r_fwd;
    t_srv_entry       r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd       <= mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok    <= '0;
            r_rd_ok <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_ok[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_ok[i_rd_addr];
                r_fwd   <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    always_comb begin
        if (r_fwd) begin
            o_rd_data = r_fwd_data;
        end else if (r_rd_ok) begin
            o_rd_data = r_rd;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

FILE: rtl/core/greedy_job_server_assigner_top.sv
// ============================================================================
// greedy_job_server_assigner_top
// Greedy job to server assignment over time-limited servers.
//
// Channel  Direction  Handshake            Payload
// input    in         i_valid / o_stall    i_data (t_in_beat)
// output   out        o_valid / i_stall    o_data (t_out_beat)
// config   in         i_cfg_we             i_cfg_wdata (local cost)
//
// One beat is taken every cycle unless o_stall is high; results are registered.
// The server entry memory is read when a beat is taken and written back as the
// beat leaves stage one, with the write forwarded to a read of the same entry.
// Reset is synchronous and leaves all servers unloaded with zero capacity.
// Input stalls only while a result is waiting and the output is stalled.
// ============================================================================
`include "greedy_job_server_assigner_top_macros.svh"

module greedy_job_server_assigner_top #(
    parameter int NUM_SERVERS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  gjsa_pkg::t_in_beat   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output gjsa_pkg::t_out_beat  o_data,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata
);
    import gjsa_pkg::*;

    localparam int AW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int XW = AW + SRV_W;

    logic                r_s1_valid;
    t_in_beat            r_s1;
    logic                r_o_valid;
    t_out_beat           r_o_data;
    logic [COST_W-1:0]   r_local_cost;
    logic [SUM_W-1:0]    r_grand;
    logic                r_found;
    logic [BEST_W-1:0]   r_best_time;
    logic [AW-1:0]       r_best_srv;
    logic [COST_W-1:0]   r_best_cost;
    t_srv_entry          r_best_ent;

    logic                accept;
    logic [XW-1:0]       in_ext;
    logic [XW-1:0]       s1_ext;
    logic [AW-1:0]       in_addr;
    logic [AW-1:0]       s1_addr;
    logic                s1_in_range;
    logic                s1_result;
    logic                blocked;
    logic                fire;
    t_srv_entry          cur;
    logic                cand;
    logic                eff_found;
    logic [BEST_W-1:0]   eff_time;
    logic [AW-1:0]       eff_srv;
    logic [COST_W-1:0]   eff_cost;
    t_srv_entry          eff_ent;
    t_srv_entry          upd_ent;
    t_srv_entry          load_ent;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W:0]      grand_wide;
    logic [COST_W-1:0]   charged;
    logic [XW-1:0]       eff_ext;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    t_srv_entry          wr_data;
    logic [SUM_W-1:0]    n_grand;
    t_out_beat           n_o_data;

    assign in_ext      = {{AW{1'b0}}, i_data.server_index};
    assign s1_ext      = {{AW{1'b0}}, r_s1.server_index};
    assign in_addr     = in_ext[AW-1:0];
    assign s1_addr     = s1_ext[AW-1:0];
    assign s1_in_range = s1_ext < XW'(NUM_SERVERS);
    assign s1_result   = (r_s1.opcode == OP_OFFER) && r_s1.last_server;
    assign blocked     = r_s1_valid && s1_result && r_o_valid && i_stall;
    assign fire        = r_s1_valid && !blocked;
    assign o_stall     = blocked;
    assign accept      = i_valid && !o_stall;

    gjsa_entry_store #(
        .DEPTH (NUM_SERVERS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (in_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (cur)
    );

    always_comb begin
        cand = (r_s1.opcode == OP_OFFER) && s1_in_range
            && (cur.remaining_capacity >= {{(CAP_W-TIME_W){1'b0}}, r_s1.run_time})
            && ({1'b0, r_s1.run_time} < r_best_time);
        eff_found = r_found || cand;
        eff_time  = cand ? {1'b0, r_s1.run_time} : r_best_time;
        eff_srv   = cand ? s1_addr : r_best_srv;
        eff_cost  = cand ? r_s1.job_cost : r_best_cost;
        eff_ent   = cand ? cur : r_best_ent;

        if (eff_ent.remaining_capacity >= {{(CAP_W-BEST_W){1'b0}}, eff_time}) begin
            upd_ent.remaining_capacity = eff_ent.remaining_capacity
                - {{(CAP_W-BEST_W){1'b0}}, eff_time};
        end else begin
            upd_ent.remaining_capacity = '0;
        end
        sum_wide = {1'b0, eff_ent.server_cost_sum} + {{(SUM_W+1-COST_W){1'b0}}, eff_cost};
        upd_ent.server_cost_sum = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        upd_ent.jobs_on_server = (eff_ent.jobs_on_server == CNT_MAX)
            ? CNT_MAX : eff_ent.jobs_on_server + CNT_W'(1);

        load_ent.remaining_capacity = r_s1.capacity;
        load_ent.server_cost_sum    = '0;
        load_ent.jobs_on_server     = '0;

        charged    = eff_found ? eff_cost : r_local_cost;
        grand_wide = {1'b0, r_grand} + {{(SUM_W+1-COST_W){1'b0}}, charged};
        n_grand    = grand_wide[SUM_W] ? SUM_MAX : grand_wide[SUM_W-1:0];

        if (r_s1.opcode == OP_LOAD) begin
            wr_en   = fire && s1_in_range;
            wr_addr = s1_addr;
            wr_data = load_ent;
        end else begin
            wr_en   = fire && s1_result && eff_found;
            wr_addr = eff_srv;
            wr_data = upd_ent;
        end

        eff_ext                   = {{SRV_W{1'b0}}, eff_srv};
        n_o_data.job_number       = r_s1.job_index;
        n_o_data.assigned         = eff_found;
        n_o_data.chosen_server    = eff_found ? eff_ext[SRV_W-1:0] : '0;
        n_o_data.charged_cost     = charged;
        n_o_data.server_job_count = eff_found ? upd_ent.jobs_on_server : '0;
        n_o_data.total_cost       = n_grand;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= i_data;
        end
        if (fire && s1_result) begin
            r_o_data <= n_o_data;
        end
        if (fire && (r_s1.opcode == OP_OFFER) && !r_s1.last_server && cand) begin
            r_best_ent <= cur;
        end else if (fire && (r_s1.opcode == OP_LOAD) && s1_in_range && r_found
                     && (r_best_srv == s1_addr)) begin
            r_best_ent <= load_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_o_valid    <= 1'b0;
            r_local_cost <= '0;
            r_grand      <= '0;
            r_found      <= 1'b0;
            r_best_time  <= NO_TIME;
            r_best_srv   <= '0;
            r_best_cost  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_local_cost <= i_cfg_wdata;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (fire) begin
                r_s1_valid <= 1'b0;
            end
            if (fire && s1_result) begin
                r_o_valid <= 1'b1;
                r_grand   <= n_grand;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (fire && (r_s1.opcode == OP_OFFER)) begin
                if (r_s1.last_server) begin
                    r_found     <= 1'b0;
                    r_best_time <= NO_TIME;
                    r_best_srv  <= '0;
                    r_best_cost <= '0;
                end else if (cand) begin
                    r_found     <= 1'b1;
                    r_best_time <= {1'b0, r_s1.run_time};
                    r_best_srv  <= s1_addr;
                    r_best_cost <= r_s1.job_cost;
                end
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

    `GJSA_ASSERT(a_result_lands, (fire && s1_result) |=> o_valid, "Result beat was not presented.")
    `GJSA_ASSERT(a_found_time, r_found == (r_best_time != NO_TIME), "Candidate flag and time disagree.")
    `GJSA_ASSERT(a_found_srv, r_found |-> ({{SRV_W{1'b0}}, r_best_srv} < XW'(NUM_SERVERS)), "Chosen server is out of range.")
    `GJSA_ASSERT_ALWAYS(a_stall_cause, o_stall |-> (r_s1_valid && r_o_valid && i_stall), "Input stalled without a waiting result.")

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking testbench for the greedy job server assigner.
// A driver feeds input beats from a queue and predicts each decision as the
// beat is taken. A monitor compares every result beat with the oldest
// predicted decision. Both sides idle at random, the receiver holds off once
// for a long stretch, and a final part runs without idling.
// ============================================================================
module tb_top;
    import gjsa_pkg::*;

    localparam int NSRV      = 8;
    localparam int HOLD_LEN  = 300;
    localparam int WDOG_MAX  = 2000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_in_beat   i_data = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_out_beat  o_data;
    logic       i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    greedy_job_server_assigner_top #(.NUM_SERVERS(NSRV)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    t_in_beat  beat_q[$];
    t_out_beat decision_q[$];

    logic [CAP_W-1:0]  cap_left [NSRV];
    logic [SUM_W-1:0]  cost_sum [NSRV];
    logic [CNT_W-1:0]  job_cnt  [NSRV];
    logic [SUM_W-1:0]  grand_sum;
    logic [SUM_W-1:0]  local_sum;
    logic [BEST_W-1:0] min_time;
    logic [SRV_W-1:0]  min_srv;
    logic [COST_W-1:0] min_cost;
    logic              have_fit;
    logic [COST_W-1:0] local_charge;

    int  error_count = 0;
    int  beats_in = 0;
    int  beats_out = 0;
    int  stalled_cycles = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  hold_asked = 0;
    int  hold_seen = 0;
    int  quiet_cycles = 0;
    bit  bursts_on = 1'b1;

    task automatic report_error(string msg);
        $display("tb: error at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("result %0d %s got %0h expected %0h",
                                   beats_out, name, got, want));
        end
    endtask

    function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = a + b;
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    function automatic t_in_beat rand_beat();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(t_in_beat)-1:0];
    endfunction

    // Updates the assignment state for one taken beat and queues its decision.
    function automatic void track_assignment(t_in_beat b);
        t_out_beat r;
        int        s;
        s = int'(b.server_index);
        if (b.opcode == OP_LOAD) begin
            if (s < NSRV) begin
                cap_left[s] = b.capacity;
                cost_sum[s] = '0;
                job_cnt[s]  = '0;
            end
            return;
        end
        if (s < NSRV && cap_left[s] >= b.run_time && {1'b0, b.run_time} < min_time) begin
            min_time = {1'b0, b.run_time};
            min_srv  = b.server_index;
            min_cost = b.job_cost;
            have_fit = 1'b1;
        end
        if (!b.last_server) begin
            return;
        end
        r.job_number = b.job_index;
        if (have_fit && int'(min_srv) < NSRV) begin
            if (cap_left[min_srv] >= min_time) begin
                cap_left[min_srv] = cap_left[min_srv] - min_time;
            end else begin
                cap_left[min_srv] = '0;
            end
            cost_sum[min_srv] = sat_sum(cost_sum[min_srv], {16'h0, min_cost});
            if (job_cnt[min_srv] != CNT_MAX) begin
                job_cnt[min_srv] = job_cnt[min_srv] + 1'b1;
            end
            r.assigned         = 1'b1;
            r.chosen_server    = min_srv;
            r.charged_cost     = min_cost;
            r.server_job_count = job_cnt[min_srv];
        end else begin
            r.assigned         = 1'b0;
            r.chosen_server    = '0;
            r.charged_cost     = local_charge;
            r.server_job_count = '0;
            local_sum = sat_sum(local_sum, {16'h0, local_charge});
        end
        grand_sum = sat_sum(grand_sum, {16'h0, r.charged_cost});
        r.total_cost = grand_sum;
        decision_q.push_back(r);
        min_time = NO_TIME;
        min_srv  = '0;
        min_cost = '0;
        have_fit = 1'b0;
    endfunction

    always @(posedge i_clk) begin : driver
        logic took;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            took = i_valid && !o_stall;
            if (took) begin
                track_assignment(i_data);
                beats_in++;
            end
            if (took || !i_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (beat_q.size() > 0) begin
                    i_data  <= beat_q.pop_front();
                    i_valid <= 1'b1;
                    if (bursts_on && $urandom_range(0, 9) == 0) begin
                        send_gap = $urandom_range(1, 19);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out_beat want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                beats_out++;
                if (decision_q.size() == 0) begin
                    report_error($sformatf("result %0d arrived with none expected", beats_out));
                end else begin
                    want = decision_q.pop_front();
                    check_field("job_number", 32'(o_data.job_number), 32'(want.job_number));
                    check_field("assigned", 32'(o_data.assigned), 32'(want.assigned));
                    check_field("chosen_server", 32'(o_data.chosen_server),
                                32'(want.chosen_server));
                    check_field("charged_cost", 32'(o_data.charged_cost),
                                32'(want.charged_cost));
                    check_field("server_job_count", 32'(o_data.server_job_count),
                                32'(want.server_job_count));
                    check_field("total_cost", o_data.total_cost, want.total_cost);
                end
            end
            if (hold_seen != hold_asked) begin
                hold_seen = hold_asked;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (bursts_on && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 18);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if (i_valid && o_stall) begin
                stalled_cycles++;
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WDOG_MAX) begin
                $display("tb: no beat moved for %0d cycles", WDOG_MAX);
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic push_load(logic [SRV_W-1:0] srv, logic [CAP_W-1:0] cap);
        t_in_beat b;
        b = rand_beat();
        b.opcode       = OP_LOAD;
        b.server_index = srv;
        b.capacity     = cap;
        beat_q.push_back(b);
    endtask

    task automatic push_offer(logic [JOB_W-1:0] job, logic [SRV_W-1:0] srv,
                              logic [TIME_W-1:0] rt, logic [COST_W-1:0] cost, logic last);
        t_in_beat b;
        b = rand_beat();
        b.opcode       = OP_OFFER;
        b.job_index    = job;
        b.server_index = srv;
        b.run_time     = rt;
        b.job_cost     = cost;
        b.last_server  = last;
        beat_q.push_back(b);
    endtask

    function automatic logic [CAP_W-1:0] pick_cap();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return CAP_W'($urandom);
            default: return CAP_W'($urandom_range(0, 3000));
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return TIME_W'($urandom);
            default: return TIME_W'($urandom_range(0, 300));
        endcase
    endfunction

    task automatic wait_idle();
        @(posedge i_clk);
        while (beat_q.size() != 0 || i_valid || decision_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_local_cost(logic [15:0] v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        local_charge = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly well-formed jobs; some loads, stray beats and loads inside a job.
    task automatic random_jobs(int n_items);
        int               added;
        int               n_off;
        logic [JOB_W-1:0] job;
        t_in_beat         b;
        added = 0;
        while (added < n_items) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    push_load(SRV_W'($urandom_range(0, NSRV - 1)), pick_cap());
                    added++;
                end
                2: begin
                    b = rand_beat();
                    beat_q.push_back(b);
                    added++;
                end
                default: begin
                    n_off = $urandom_range(1, NSRV);
                    job   = JOB_W'($urandom);
                    for (int k = 0; k < n_off; k++) begin
                        if ($urandom_range(0, 23) == 0) begin
                            push_load(SRV_W'($urandom_range(0, NSRV - 1)), pick_cap());
                        end
                        if ($urandom_range(0, 15) == 0) begin
                            job = JOB_W'($urandom);
                        end
                        push_offer(job, SRV_W'($urandom_range(0, NSRV - 1)), pick_time(),
                                   COST_W'($urandom), k == n_off - 1);
                    end
                    added += n_off;
                end
            endcase
        end
    endtask

    initial begin : stimulus
        for (int s = 0; s < NSRV; s++) begin
            cap_left[s] = '0;
            cost_sum[s] = '0;
            job_cnt[s]  = '0;
        end
        grand_sum    = '0;
        local_sum    = '0;
        min_time     = NO_TIME;
        min_srv      = '0;
        min_cost     = '0;
        have_fit     = 1'b0;
        local_charge = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_offer(16'h0000, 3'd0, 16'd0, 16'h1234, 1'b1);
        push_offer(16'h0001, 3'd1, 16'd5, 16'h0007, 1'b1);
        set_local_cost(16'hFFFF);
        push_load(3'd7, 24'hFFFFFF);
        push_load(3'd3, 24'd10);
        push_offer(16'h0002, 3'd7, 16'd10, 16'h0001, 1'b0);
        push_offer(16'h0003, 3'd3, 16'd10, 16'h0002, 1'b0);
        push_offer(16'hFFFF, 3'd5, 16'd3, 16'h0003, 1'b1);
        push_offer(16'h0005, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1);
        push_offer(16'h0006, 3'd3, 16'd11, 16'h0009, 1'b1);
        push_offer(16'h0007, 3'd3, 16'd10, 16'h0005, 1'b0);
        push_load(3'd3, 24'd4);
        push_offer(16'h0007, 3'd0, 16'd100, 16'h0006, 1'b1);
        push_load(3'd2, 24'd0);
        push_offer(16'h0008, 3'd2, 16'd0, 16'h0000, 1'b1);
        for (int s = NSRV - 1; s >= 0; s--) begin
            push_offer(16'h0009, SRV_W'(s), (s == 3) ? 16'd0 : TIME_W'(20 - s),
                       COST_W'(16'h00A0 + s), s == 0);
        end

        random_jobs(290);
        set_local_cost(16'h0000);
        random_jobs(290);
        set_local_cost(16'($urandom));
        random_jobs(290);

        // Receiver holds off while single-offer jobs keep arriving.
        wait_idle();
        hold_asked++;
        for (int k = 0; k < 40; k++) begin
            push_offer(JOB_W'($urandom), SRV_W'($urandom_range(0, NSRV - 1)), pick_time(),
                       COST_W'($urandom), 1'b1);
        end
        set_local_cost(16'($urandom));
        random_jobs(290);
        wait_idle();

        bursts_on = 1'b0;
        random_jobs(200);
        wait_idle();
        repeat (8) @(posedge i_clk);

        if (decision_q.size() != 0) begin
            report_error($sformatf("%0d decisions never arrived", decision_q.size()));
        end
        $display("tb: %0d beats in, %0d results, %0d cycles with input stalled",
                 beats_in, beats_out, stalled_cycles);
        $display("tb: loads, ties, local runs and capacity reloads exercised under stalls");
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/gjsa_pkg.sv
rtl/core/gjsa_entry_store.sv
rtl/core/greedy_job_server_assigner_top.sv
sim/tb_top.sv
